// ===== rtl/hasf_pkg.sv =====
// Shared types, constants and helper functions of the high-ASCII segment filter.
package hasf_pkg;

	// Segment store geometry: one bank holds one segment, two banks alternate.
	localparam int STORE_DEPTH = 63;
	localparam int IDX_W = 6;
	localparam int BANK_COUNT = 2;
	localparam int RAM_DEPTH = BANK_COUNT * (1 << IDX_W);
	localparam int RAM_ADDR_W = IDX_W + 1;
	localparam int DEFAULT_SEGMENT_CAPACITY = 63;

	// Character codes used by the classifier and the emitter.
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
	localparam logic [7:0] SPACE_BYTE = 8'h20;

	// One finished segment handed from the front to the back.
	typedef struct packed {
		logic             bank;
		logic [IDX_W-1:0] len;
	} job_t;

	// The back returns a bank once its segment has been fully emitted.
	typedef struct packed {
		logic valid;
		logic bank;
	} release_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_BYTES,
		B_SPACE
	} back_state_t;

	// A segment byte is a letter or any byte with its top bit set.
	function automatic logic is_segment_byte(input logic [7:0] b);
		logic res;
		res = b[7]
			|| ((b >= CHAR_UPPER_A) && (b <= CHAR_UPPER_Z))
			|| ((b >= CHAR_LOWER_A) && (b <= CHAR_LOWER_Z));
		return res;
	endfunction

endpackage

// ===== rtl/hasf_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
module hasf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/hasf_front.sv =====
// Front end: accepts input words, classifies them and fills the segment banks.
module hasf_front #(
	parameter int SEGMENT_CAPACITY = hasf_pkg::DEFAULT_SEGMENT_CAPACITY
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic [7:0]                      data_byte,
	input  logic                            end_of_buffer,
	input  hasf_pkg::release_t              rel,
	output logic                            ram_we,
	output logic [hasf_pkg::RAM_ADDR_W-1:0] ram_waddr,
	output logic [7:0]                      ram_wdata,
	output logic                            job_push,
	output hasf_pkg::job_t                  job
);
	import hasf_pkg::*;

	localparam logic [IDX_W-1:0] CAP_L = IDX_W'(SEGMENT_CAPACITY);

	logic                 wr_bank_q;
	logic [IDX_W-1:0]     len_q;
	logic                 high_q;
	logic                 ovf_q;
	logic [BANK_COUNT-1:0] busy_q;

	logic accept;
	logic seg;
	logic keep;
	logic [BANK_COUNT-1:0] busy_set;
	logic [BANK_COUNT-1:0] busy_clr;

	// A new word is taken only while the bank being filled is free.
	assign full   = busy_q[wr_bank_q];
	assign accept = push && !full;
	assign seg    = is_segment_byte(data_byte);
	assign keep   = high_q && !ovf_q && (len_q != '0);

	// Store segment bytes while there is room in the bank.
	assign ram_we    = accept && seg && (len_q < CAP_L);
	assign ram_waddr = {wr_bank_q, len_q};
	assign ram_wdata = data_byte;

	// A delimiter closes a kept segment and hands its bank to the back.
	assign job_push = accept && !seg && keep;
	assign job.bank = wr_bank_q;
	assign job.len  = len_q;

	// Bank ownership flags: set on handoff, cleared when the back releases.
	always_comb begin
		busy_set = '0;
		busy_clr = '0;
		if (job_push) begin
			busy_set[wr_bank_q] = 1'b1;
		end
		if (rel.valid) begin
			busy_clr[rel.bank] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= '0;
		end else begin
			busy_q <= (busy_q & ~busy_clr) | busy_set;
		end
	end

	// Segment tracking state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_bank_q <= 1'b0;
			len_q     <= '0;
			high_q    <= 1'b0;
			ovf_q     <= 1'b0;
		end else if (accept) begin
			if (job_push) begin
				wr_bank_q <= !wr_bank_q;
			end
			if (!seg || end_of_buffer) begin
				len_q  <= '0;
				high_q <= 1'b0;
				ovf_q  <= 1'b0;
			end else begin
				if (data_byte[7]) begin
					high_q <= 1'b1;
				end
				if (len_q < CAP_L) begin
					len_q <= len_q + 1'b1;
				end else begin
					ovf_q <= 1'b1;
				end
			end
		end
	end

endmodule

// ===== rtl/hasf_queue.sv =====
// Two-entry job queue between the front and the back.
module hasf_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  hasf_pkg::job_t push_job,
	input  logic           pop,
	output logic           empty,
	output hasf_pkg::job_t head
);
	import hasf_pkg::*;

	job_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign empty = (count_q == 2'd0);
	assign head  = entry_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/hasf_back.sv =====
// Back end: reads a finished segment from its bank and emits it followed by a space.
module hasf_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            job_empty,
	input  hasf_pkg::job_t                  job,
	output logic                            job_pop,
	output logic                            ram_re,
	output logic [hasf_pkg::RAM_ADDR_W-1:0] ram_raddr,
	input  logic [7:0]                      ram_rdata,
	output hasf_pkg::release_t              rel,
	output logic                            empty,
	input  logic                            pop,
	output logic [7:0]                      out_byte,
	output logic                            last_of_run
);
	import hasf_pkg::*;

	back_state_t      state_q;
	back_state_t      state_d;
	logic             bank_q;
	logic [IDX_W-1:0] len_q;
	logic [IDX_W-1:0] cnt_q;
	logic             rd_pend_q;
	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic             out_last_q;

	logic slot_free;
	logic issue;
	logic load_space;

	assign slot_free = !out_valid_q || pop;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (!job_empty) begin
					state_d = B_BYTES;
				end
			end
			B_BYTES: begin
				if (cnt_q == len_q) begin
					state_d = B_SPACE;
				end
			end
			B_SPACE: begin
				if (!rd_pend_q && slot_free) begin
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	// Control outputs of the sequencer.
	always_comb begin
		job_pop    = 1'b0;
		issue      = 1'b0;
		load_space = 1'b0;
		unique case (state_q)
			B_IDLE:  job_pop = !job_empty;
			B_BYTES: issue = (cnt_q != len_q) && !rd_pend_q && slot_free;
			B_SPACE: load_space = !rd_pend_q && slot_free;
			default: ;
		endcase
	end

	assign ram_re     = issue;
	assign ram_raddr  = {bank_q, cnt_q};
	assign rel.valid  = load_space;
	assign rel.bank   = bank_q;

	// Sequencer registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_IDLE;
			rd_pend_q <= 1'b0;
			cnt_q     <= '0;
		end else begin
			state_q   <= state_d;
			rd_pend_q <= issue;
			if (job_pop) begin
				cnt_q <= '0;
			end else if (issue) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// Job details latched when a segment is taken.
	always_ff @(posedge clk) begin
		if (job_pop) begin
			bank_q <= job.bank;
			len_q  <= job.len;
		end
	end

	// Output register: holds the oldest result word until it is popped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rd_pend_q || load_space) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_pend_q) begin
			out_byte_q <= ram_rdata;
			out_last_q <= 1'b0;
		end else if (load_space) begin
			out_byte_q <= SPACE_BYTE;
			out_last_q <= 1'b1;
		end
	end

	assign empty       = !out_valid_q;
	assign out_byte    = out_byte_q;
	assign last_of_run = out_last_q;

endmodule

// ===== rtl/high_ascii_segment_filter.sv =====
// Top level of the high-ASCII segment filter.
//
// Input channel: push/full. A word (data_byte, end_of_buffer) is taken at a
// clock edge with push high and full low. Letters and bytes with the top bit
// set build a segment; any other byte is a delimiter. end_of_buffer drops the
// segment that is still open after that byte has been handled.
// Result channel: empty/pop. While empty is low the oldest result is on
// out_byte/last_of_run; it is taken at an edge with pop high.
// A kept segment comes out byte by byte, then a space with last_of_run set.
// Throughput: the front takes one word per cycle while a bank is free. The back
// reads a segment byte from the RAM only once the previous read has left the
// registered read port and the output register has room; the space follows the
// last byte, and the next segment is taken after the space has been loaded.
// Path: the first byte of a kept segment passes through the job queue, the back's
// job pop, the registered RAM read and the output register after its delimiter.
// Two banks of the segment RAM alternate; full rises while the front waits for
// the back to give up the bank it needs next, so a stalled receiver backs up
// into the input side after at most two finished segments.
// Reset clears all control state; the RAM contents are left as they are.
module high_ascii_segment_filter #(
	parameter int SEGMENT_CAPACITY = hasf_pkg::DEFAULT_SEGMENT_CAPACITY
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] data_byte,
	input  logic       end_of_buffer,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_byte,
	output logic       last_of_run
);
	import hasf_pkg::*;

	logic                  ram_we;
	logic [RAM_ADDR_W-1:0] ram_waddr;
	logic [7:0]            ram_wdata;
	logic                  ram_re;
	logic [RAM_ADDR_W-1:0] ram_raddr;
	logic [7:0]            ram_rdata;
	logic                  job_push;
	job_t                  push_job;
	logic                  job_pop;
	logic                  job_empty;
	job_t                  head_job;
	release_t              rel;

	// Classifier and bank filler.
	hasf_front #(
		.SEGMENT_CAPACITY(SEGMENT_CAPACITY)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.data_byte    (data_byte),
		.end_of_buffer(end_of_buffer),
		.rel          (rel),
		.ram_we       (ram_we),
		.ram_waddr    (ram_waddr),
		.ram_wdata    (ram_wdata),
		.job_push     (job_push),
		.job          (push_job)
	);

	// Segment store, two banks.
	hasf_ram #(
		.WIDTH(8),
		.DEPTH(RAM_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Finished segments waiting for the back.
	hasf_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (job_push),
		.push_job(push_job),
		.pop     (job_pop),
		.empty   (job_empty),
		.head    (head_job)
	);

	// Emitter.
	hasf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_empty  (job_empty),
		.job        (head_job),
		.job_pop    (job_pop),
		.ram_re     (ram_re),
		.ram_raddr  (ram_raddr),
		.ram_rdata  (ram_rdata),
		.rel        (rel),
		.empty      (empty),
		.pop        (pop),
		.out_byte   (out_byte),
		.last_of_run(last_of_run)
	);

endmodule

// ===== rtl/hasf_checker.sv =====
// Port-level checker for the high-ASCII segment filter, with its bind.
module hasf_port_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       push,
	input logic       full,
	input logic [7:0] data_byte,
	input logic       end_of_buffer,
	input logic       empty,
	input logic       pop,
	input logic [7:0] out_byte,
	input logic       last_of_run
);
	import hasf_pkg::*;

	// A waiting result word holds until it is popped.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(last_of_run)))
		else $error("result word changed while waiting");

	// The closing word of a run is always a space.
	a_last_space: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && last_of_run) |-> (out_byte == SPACE_BYTE))
		else $error("closing word is not a space");

	// Every other result word is a segment byte.
	a_seg_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !last_of_run) |-> is_segment_byte(out_byte))
		else $error("emitted byte is a delimiter");

	// No result word is waiting in the cycle after reset.
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |=> empty)
		else $error("result present right after reset");

endmodule

bind high_ascii_segment_filter hasf_port_checker u_hasf_checker (.*);

// ===== tb/hasf_checker.sv =====
// Checker for the high-ASCII segment filter: predicts result words and compares them.
module hasf_checker #(
	parameter int CAPACITY = hasf_pkg::DEFAULT_SEGMENT_CAPACITY
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic       full,
	input  logic [7:0] data_byte,
	input  logic       end_of_buffer,
	input  logic       empty,
	input  logic       pop,
	input  logic [7:0] out_byte,
	input  logic       last_of_run,
	output int         error_count,
	output int         words_pending
);
	import hasf_pkg::*;

	typedef struct packed {
		logic [7:0] value;
		logic       last;
	} out_word_t;

	// The store never holds more than its depth, whatever the parameter says.
	localparam int HELD_MAX = (CAPACITY > STORE_DEPTH) ? STORE_DEPTH : CAPACITY;

	// Predicted state of the segment being collected.
	logic [7:0]  held [0:STORE_DEPTH-1];
	int unsigned held_len;
	logic        held_high;
	logic        held_over;

	// Result words predicted but not yet seen, oldest first.
	out_word_t expected_words[$];
	int        errors;

	// Letters and bytes with the top bit set extend a segment.
	function automatic logic letter_or_high(input logic [7:0] b);
		return b[7] || (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z)
			|| (b >= CHAR_LOWER_A && b <= CHAR_LOWER_Z);
	endfunction

	task automatic drop_segment();
		held_len = 0;
		held_high = 1'b0;
		held_over = 1'b0;
	endtask

	// Feed one accepted input word and queue the result words it releases.
	task automatic filter_byte(input logic [7:0] b, input logic eob);
		out_word_t w;
		int unsigned i;
		if (letter_or_high(b)) begin
			if (b[7])
				held_high = 1'b1;
			if (held_len < HELD_MAX) begin
				held[held_len] = b;
				held_len++;
			end else begin
				held_over = 1'b1;
			end
		end else begin
			// A delimiter releases a kept segment and its closing space.
			if (held_high && !held_over && held_len > 0) begin
				for (i = 0; i < held_len; i++) begin
					w.value = held[i];
					w.last = 1'b0;
					expected_words.push_back(w);
				end
				w.value = SPACE_BYTE;
				w.last = 1'b1;
				expected_words.push_back(w);
			end
			drop_segment();
		end
		// The end of a buffer throws away whatever segment is still open.
		if (eob)
			drop_segment();
	endtask

	// Watch both channels at each edge.
	always @(posedge clk or negedge arst_n) begin : watch
		out_word_t want;
		if (!arst_n) begin
			drop_segment();
			expected_words.delete();
			errors = 0;
			error_count <= 0;
			words_pending <= 0;
		end else begin
			if (push && !full)
				filter_byte(data_byte, end_of_buffer);
			if (pop && !empty) begin
				if (expected_words.size() == 0) begin
					errors++;
					$display("%0t: unexpected result word: expected none, actual %h/%b",
						$time, out_byte, last_of_run);
				end else begin
					want = expected_words.pop_front();
					if (out_byte !== want.value) begin
						errors++;
						$display("%0t: out_byte mismatch: expected %h, actual %h",
							$time, want.value, out_byte);
					end
					if (last_of_run !== want.last) begin
						errors++;
						$display("%0t: last_of_run mismatch: expected %b, actual %b",
							$time, want.last, last_of_run);
					end
				end
			end
			error_count <= errors;
			words_pending <= expected_words.size();
		end
	end

endmodule

// ===== tb/tb.sv =====
// Testbench top for the high-ASCII segment filter: stimulus, flow control and verdict.
module tb;
	import hasf_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_WORDS = 50;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic [7:0] data_byte = 8'h00;
	logic       end_of_buffer = 1'b0;
	logic       pop = 1'b0;
	logic       full;
	logic       empty;
	logic [7:0] out_byte;
	logic       last_of_run;

	int error_count;
	int words_pending;
	int cycle_count = 0;
	int words_sent = 0;
	int send_idle_pct = 0;
	int pop_stall_pct = 0;
	logic hold_pop = 1'b0;

	high_ascii_segment_filter dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.data_byte    (data_byte),
		.end_of_buffer(end_of_buffer),
		.empty        (empty),
		.pop          (pop),
		.out_byte     (out_byte),
		.last_of_run  (last_of_run)
	);

	hasf_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.data_byte    (data_byte),
		.end_of_buffer(end_of_buffer),
		.empty        (empty),
		.pop          (pop),
		.out_byte     (out_byte),
		.last_of_run  (last_of_run),
		.error_count  (error_count),
		.words_pending(words_pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("high_ascii_segment_filter test failed");
			$finish;
		end
	end

	// The receiver pops at random, or not at all during a hold-off.
	always @(posedge clk) begin
		if (!arst_n)
			pop <= 1'b0;
		else
			pop <= !hold_pop && ($urandom_range(99) >= pop_stall_pct);
	end

	function automatic logic [7:0] rand_high();
		return 8'($urandom_range(255, 128));
	endfunction

	function automatic logic [7:0] rand_letter();
		if ($urandom_range(1) == 0)
			return CHAR_UPPER_A + 8'($urandom_range(25));
		return CHAR_LOWER_A + 8'($urandom_range(25));
	endfunction

	// Any byte that is neither a letter nor high.
	function automatic logic [7:0] rand_delim();
		case ($urandom_range(2))
			0: return 8'($urandom_range(64));
			1: return 8'($urandom_range(96, 91));
			default: return 8'($urandom_range(127, 123));
		endcase
	endfunction

	// Offer one word and wait until the block takes it.
	task automatic push_word(input logic [7:0] b, input logic eob);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		push <= 1'b1;
		data_byte <= b;
		end_of_buffer <= eob;
		@(posedge clk);
		while (full)
			@(posedge clk);
		words_sent++;
	endtask

	// One segment of letters, with high bytes mixed in if asked; eob may land on its last byte.
	task automatic send_segment(input int len, input logic with_high, input logic eob_last);
		int hi_pos;
		int i;
		logic [7:0] b;
		hi_pos = $urandom_range(len - 1);
		for (i = 0; i < len; i++) begin
			if (with_high && (i == hi_pos || $urandom_range(3) == 0))
				b = rand_high();
			else
				b = rand_letter();
			push_word(b, eob_last && i == len - 1);
		end
	endtask

	// A well-formed segment followed by one of several endings.
	task automatic send_random_segment(input int len);
		int ending;
		logic with_high;
		ending = $urandom_range(9);
		with_high = $urandom_range(99) < 75;
		send_segment(len, with_high, ending == 0);
		case (ending)
			0: ;
			1: push_word(rand_delim(), 1'b1);
			2: begin
				push_word(rand_delim(), 1'b0);
				push_word(rand_delim(), 1'b0);
			end
			default: push_word(rand_delim(), 1'b0);
		endcase
	endtask

	int idle_by_phase [4] = '{0, 65, 0, 38};
	int stall_by_phase [4] = '{0, 0, 65, 38};

	initial begin
		int phase;
		int target;
		int len;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: a kept segment ended by a space.
		push_word(8'hC3, 1'b0);
		push_word(CHAR_LOWER_A, 1'b0);
		push_word(CHAR_UPPER_Z, 1'b0);
		push_word(SPACE_BYTE, 1'b0);
		// A delimiter with no segment before it.
		push_word(8'h2C, 1'b0);
		// Plain letters only: dropped.
		push_word(CHAR_UPPER_A, 1'b0);
		push_word(CHAR_LOWER_Z, 1'b0);
		push_word(8'h2E, 1'b0);
		// Extreme high bytes, closed by a null byte.
		push_word(8'h80, 1'b0);
		push_word(8'hFF, 1'b0);
		push_word(8'h00, 1'b0);
		// Bytes just outside the letter ranges are delimiters.
		push_word(8'h40, 1'b0);
		push_word(8'h5B, 1'b0);
		push_word(8'h60, 1'b0);
		push_word(8'h7B, 1'b0);
		push_word(8'h7F, 1'b0);
		// A delimiter that also ends the buffer still releases its segment.
		push_word(8'h62, 1'b0);
		push_word(8'h9A, 1'b0);
		push_word(8'h21, 1'b1);
		// End of buffer on a segment byte discards it; the next delimiter emits nothing.
		push_word(8'hE0, 1'b0);
		push_word(8'h71, 1'b1);
		push_word(8'h3B, 1'b0);

		for (phase = 0; phase < 4; phase++) begin
			send_idle_pct = idle_by_phase[phase];
			pop_stall_pct <= stall_by_phase[phase];
			// Hold the receiver off while the sender keeps pushing, so the banks fill.
			if (phase == 0) begin
				fork
					begin
						hold_pop <= 1'b1;
						repeat (400) @(posedge clk);
						hold_pop <= 1'b0;
					end
				join_none
			end
			// A segment of exactly the store size, and one a byte too long.
			if (phase == 1) begin
				send_segment(STORE_DEPTH, 1'b1, 1'b0);
				push_word(SPACE_BYTE, 1'b0);
			end
			if (phase == 2) begin
				send_segment(STORE_DEPTH + 1, 1'b1, 1'b0);
				push_word(SPACE_BYTE, 1'b0);
			end
			target = words_sent + PHASE_WORDS;
			while (words_sent < target) begin
				if ($urandom_range(99) < 10) begin
					push_word(8'($urandom_range(255)), $urandom_range(7) == 0);
				end else begin
					if ($urandom_range(24) == 0)
						len = $urandom_range(STORE_DEPTH + 2, STORE_DEPTH - 3);
					else
						len = $urandom_range(8, 1);
					send_random_segment(len);
				end
			end
		end

		// Drain: wait for every predicted word, then for any stray result words.
		push <= 1'b0;
		@(posedge clk);
		while (words_pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (error_count == 0)
			$display("high_ascii_segment_filter test passed");
		else
			$display("high_ascii_segment_filter test failed");
		$finish;
	end

endmodule
